### rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes of the linear probing hash table: command and
// result payloads, table entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package lph_pkg;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_FOUND     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// table size register
	localparam int         SIZE_W          = 7;
	localparam logic [6:0] SIZE_RESET      = 7'd64;

	// key width and the remainder unit digit size
	localparam int KEY_W     = 31;
	localparam int DIGIT_W   = 4;
	localparam int KEY_PAD_W = 32;
	localparam int DIGITS    = KEY_PAD_W / DIGIT_W;
	localparam int DCNT_W    = $clog2(DIGITS);

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [31:0]      name_code;
		logic [31:0]      dept_code;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [31:0] found_name;
		logic [31:0] found_dept;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [31:0]      name;
		logic [31:0]      dept;
	} entry_t;

endpackage

### rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing, insert and search.
// ----------------------------------------------------------------------------
// One command at a time: a command is taken when start is high and busy is
// low, and its single result shows on result for exactly one cycle with done
// high; the receiver cannot stall, so results must be taken as they come.
// A command first runs the remainder unit (4 key bits a cycle) for the home
// slot, then the probe walks the slot memory one slot a cycle on its single
// read port. After reset the block clears all TABLE_DEPTH slots of the slot
// memory with busy high; table_size writes are taken at any time, but only
// while idle should they be issued.
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lph_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done,
	output lph_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SZ_W  = IDX_W + 1;
	localparam int CMP_W = (SZ_W > lph_pkg::SIZE_W) ? SZ_W : lph_pkg::SIZE_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} state_t;

	state_t              state_q;
	logic [6:0]          table_size_q;
	lph_pkg::cmd_t       cmd_q;
	logic [SZ_W-1:0]     size_q;
	logic [SZ_W-1:0]     eff_size;
	logic [IDX_W-1:0]    clr_addr_q;
	logic [IDX_W-1:0]    probe_addr_q;
	logic [SZ_W-1:0]     issue_cnt_q;
	logic                vld_s1;
	logic                last_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                done_q;
	lph_pkg::result_t    result_q;

	logic                accept;
	logic                mod_done;
	logic [SZ_W-1:0]     mod_rem;
	logic                issue;
	logic                is_insert;
	logic                key_match;
	logic                hit_stop;
	logic                stop;
	logic [IDX_W-1:0]    probe_next;
	logic                rd_en;
	lph_pkg::entry_t     rd_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	lph_pkg::entry_t     wr_data;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= lph_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// effective size, clamped to one and the table depth
	always_comb begin
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(table_size_q);
		if (ext == '0) begin
			eff_size = SZ_W'(1);
		end else if (ext > CMP_W'(TABLE_DEPTH)) begin
			eff_size = SZ_W'(TABLE_DEPTH);
		end else begin
			eff_size = SZ_W'(ext);
		end
	end

	assign accept = start && !busy;

	// home slot
	lph_mod #(
		.SZ_W(SZ_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dividend(cmd.key),
		.divisor (eff_size),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// probe decisions on the slot read back this cycle
	assign is_insert  = (cmd_q.op == lph_pkg::OP_INSERT);
	assign key_match  = rd_data.valid && (rd_data.key == cmd_q.key);
	assign hit_stop   = vld_s1 && (!rd_data.valid || (!is_insert && key_match));
	assign stop       = hit_stop || (vld_s1 && last_s1);
	assign issue      = (state_q == S_PROBE) && !stop && (issue_cnt_q != size_q);
	assign probe_next = (SZ_W'(probe_addr_q) + SZ_W'(1) == size_q) ? '0
		: probe_addr_q + 1'b1;

	// slot memory access
	assign rd_en   = issue;
	assign wr_en   = (state_q == S_CLEAR)
		|| ((state_q == S_PROBE) && vld_s1 && is_insert && !rd_data.valid);
	assign wr_addr = (state_q == S_CLEAR) ? clr_addr_q : idx_s1;
	always_comb begin
		wr_data = '0;
		if (state_q != S_CLEAR) begin
			wr_data.valid = 1'b1;
			wr_data.key   = cmd_q.key;
			wr_data.name  = cmd_q.name_code;
			wr_data.dept  = cmd_q.dept_code;
		end
	end

	lph_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(probe_addr_q),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (stop) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						vld_s1  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			size_q <= eff_size;
		end
		if (state_q == S_HASH && mod_done) begin
			probe_addr_q <= mod_rem[IDX_W-1:0];
			issue_cnt_q  <= '0;
		end else if (issue) begin
			probe_addr_q <= probe_next;
			issue_cnt_q  <= issue_cnt_q + 1'b1;
		end
		if (issue) begin
			idx_s1  <= probe_addr_q;
			last_s1 <= (issue_cnt_q == size_q - SZ_W'(1));
		end
		if (state_q == S_PROBE && stop) begin
			result_q <= '0;
			if (is_insert) begin
				if (hit_stop) begin
					result_q.status <= lph_pkg::ST_INSERTED;
					result_q.slot   <= 6'(idx_s1);
				end else begin
					result_q.status <= lph_pkg::ST_FULL;
				end
			end else if (key_match) begin
				result_q.status     <= lph_pkg::ST_FOUND;
				result_q.slot       <= 6'(idx_s1);
				result_q.found_name <= rd_data.name;
				result_q.found_dept <= rd_data.dept;
			end else begin
				result_q.status <= lph_pkg::ST_NOT_FOUND;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// checks
	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PROBE))
		else $error("result without a probe");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == lph_pkg::ST_FULL || result.status == lph_pkg::ST_NOT_FOUND)
		|-> result.slot == '0 && result.found_name == '0 && result.found_dept == '0)
		else $error("miss result carries data");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CLEAR || state_q == S_PROBE))
		else $error("slot write outside clear or probe");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("accepted command did not raise busy");

endmodule

### rtl/lph_mod.sv
// ----------------------------------------------------------------------------
// lph_mod
// Iterative remainder unit: key modulo table size, restoring method,
// several dividend bits retired per cycle.
// ----------------------------------------------------------------------------
module lph_mod #(
	parameter int SZ_W = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lph_pkg::KEY_W-1:0] dividend,
	input  logic [SZ_W-1:0]          divisor,
	output logic                     done,
	output logic [SZ_W-1:0]          rem
);

	logic                           run_q;
	logic [lph_pkg::DCNT_W-1:0]     cnt_q;
	logic [lph_pkg::KEY_PAD_W-1:0]  num_q;
	logic [SZ_W-1:0]                div_q;
	logic [SZ_W-1:0]                rem_q;
	logic [SZ_W-1:0]                rem_next;
	logic                           done_q;

	// one digit of restoring remainder steps
	always_comb begin
		logic [SZ_W:0]   t;
		logic [SZ_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < lph_pkg::DIGIT_W; i++) begin
			t = {r, num_q[lph_pkg::KEY_PAD_W-1-i]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[SZ_W-1:0];
		end
		rem_next = r;
	end

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lph_pkg::DCNT_W'(lph_pkg::DIGITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {1'b0, dividend};
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << lph_pkg::DIGIT_W;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/lph_mem.sv
// ----------------------------------------------------------------------------
// lph_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lph_mem #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output lph_pkg::entry_t       rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  lph_pkg::entry_t       wr_data
);

	lph_pkg::entry_t mem [DEPTH];
	lph_pkg::entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
